// ----- hdl/plts_pkg.sv -----
// shared types, constants and helpers for the pin level timer and sequence player
`timescale 1ns / 1ps

package plts_pkg;

  localparam int unsigned SeqDepth = 16;
  localparam int unsigned StepW    = $clog2(SeqDepth);
  localparam int unsigned LenW     = StepW + 1;
  localparam int unsigned LevelW   = 10;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned AgeW     = 32;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 32;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpLoad  = 2'd1,
    OpStart = 2'd2,
    OpAck   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RegOutputMode   = 2'd0,
    RegIdleLevel    = 2'd1,
    RegSeqLength    = 2'd2,
    RegRepeatEnable = 2'd3
  } reg_e;

  typedef struct packed {
    op_e               op;
    logic [TimeW-1:0]  elapsed;
    logic [LevelW-1:0] sample;
    logic [StepW-1:0]  entry_index;
    logic [LevelW-1:0] entry_level;
    logic [TimeW-1:0]  entry_duration;
  } req_t;

  typedef struct packed {
    logic [LevelW-1:0] drive_level;
    logic              drive_strobe;
    logic [LevelW-1:0] input_level;
    logic [AgeW-1:0]   level_age;
    logic              level_changed;
    logic              seq_running;
    logic [StepW-1:0]  seq_step;
  } rsp_t;

  typedef struct packed {
    logic              output_mode;
    logic [LevelW-1:0] idle_level;
    logic [LenW-1:0]   seq_length;
    logic              repeat_enable;
  } cfg_t;

  // 32-bit timer plus 16-bit increment, sticks at all ones
  function automatic logic [AgeW-1:0] sat_add(input logic [AgeW-1:0] a,
                                              input logic [TimeW-1:0] b);
    logic [AgeW:0] sum;
    sum = {1'b0, a} + {{(AgeW + 1 - TimeW){1'b0}}, b};
    return sum[AgeW] ? {AgeW{1'b1}} : sum[AgeW-1:0];
  endfunction

endpackage

// ----- hdl/pin_level_timer_and_sequence_player.sv -----
// top level: register port, request input stage and result register for one pin channel
//
//   channel   direction  handshake                       payload
//   apb       in/out     psel, penable, pready           paddr, pwdata, prdata
//   in        in         in_valid_i / in_stall_o         in_req_i  (req_t)
//   out       out        out_valid_o / out_stall_i       out_rsp_o (rsp_t)
//
// one request per cycle while out_stall_i is low: a request is held in the input
// register, is processed by the channel update, and its result lands in the output
// register, where it stays valid until it is taken.
// out_stall_i holds the result register; the input register keeps taking a
// request until it too is full. reset clears channel state, configuration and
// valid flags; the step table holds unknown values until loaded.
`timescale 1ns / 1ps

module pin_level_timer_and_sequence_player (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [plts_pkg::AddrW-1:0]    paddr,
  input  logic [plts_pkg::DataW-1:0]    pwdata,
  output logic [plts_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  plts_pkg::req_t                in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output plts_pkg::rsp_t                out_rsp_o
);
  import plts_pkg::*;

  cfg_t   cfg_q;
  reg_e   reg_sel;
  logic   cfg_wr;

  logic   s1_valid_q;
  req_t   s1_req_q;
  logic   out_valid_q;
  rsp_t   out_rsp_q;
  rsp_t   core_rsp;
  logic   fire;
  logic   accept_in;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.output_mode   <= 1'b0;
      cfg_q.idle_level    <= '0;
      cfg_q.seq_length    <= LenW'(1);
      cfg_q.repeat_enable <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        RegOutputMode:   cfg_q.output_mode   <= pwdata[0];
        RegIdleLevel:    cfg_q.idle_level    <= pwdata[LevelW-1:0];
        RegSeqLength:    cfg_q.seq_length    <= pwdata[LenW-1:0];
        RegRepeatEnable: cfg_q.repeat_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegOutputMode:   prdata = {{(DataW - 1){1'b0}}, cfg_q.output_mode};
      RegIdleLevel:    prdata = {{(DataW - LevelW){1'b0}}, cfg_q.idle_level};
      RegSeqLength:    prdata = {{(DataW - LenW){1'b0}}, cfg_q.seq_length};
      RegRepeatEnable: prdata = {{(DataW - 1){1'b0}}, cfg_q.repeat_enable};
      default:         prdata = '0;
    endcase
  end

  // a request moves on when the result register is free or being drained
  assign fire       = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~fire;
  assign accept_in  = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= accept_in | (s1_valid_q & ~fire);
      out_valid_q <= fire | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      s1_req_q <= in_req_i;
    end
    if (fire) begin
      out_rsp_q <= core_rsp;
    end
  end

  plts_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (fire),
    .req_i  (s1_req_q),
    .cfg_i  (cfg_q),
    .rsp_o  (core_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ----- hdl/plts_core.sv -----
// channel state and the combinational update for one request
`timescale 1ns / 1ps

module plts_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  plts_pkg::req_t req_i,
  input  plts_pkg::cfg_t cfg_i,
  output plts_pkg::rsp_t rsp_o
);
  import plts_pkg::*;

  logic [LevelW-1:0] held_level_q, held_level_d;
  logic [AgeW-1:0]   age_timer_q, age_timer_d;
  logic              change_flag_q, change_flag_d;
  logic              running_q, running_d;
  logic [StepW-1:0]  step_index_q, step_index_d;
  logic [AgeW-1:0]   step_timer_q, step_timer_d;

  logic [LevelW-1:0] step_levels_q [SeqDepth];
  logic [TimeW-1:0]  step_durations_q [SeqDepth];

  logic [LenW-1:0]   eff_len;
  logic [LenW-1:0]   next_idx;
  logic [AgeW-1:0]   timer_sum;
  logic [LevelW-1:0] drive;
  logic              strobe;

  // zero length counts as one, too long counts as the full table
  always_comb begin
    if (cfg_i.seq_length == '0) begin
      eff_len = LenW'(1);
    end else if (cfg_i.seq_length > LenW'(SeqDepth)) begin
      eff_len = LenW'(SeqDepth);
    end else begin
      eff_len = cfg_i.seq_length;
    end
  end

  assign next_idx  = {1'b0, step_index_q} + LenW'(1);
  assign timer_sum = sat_add(step_timer_q, req_i.elapsed);

  always_comb begin
    held_level_d  = held_level_q;
    age_timer_d   = age_timer_q;
    change_flag_d = change_flag_q;
    running_d     = running_q;
    step_index_d  = step_index_q;
    step_timer_d  = step_timer_q;
    drive         = '0;
    strobe        = 1'b0;
    case (req_i.op)
      OpTick: begin
        if (!cfg_i.output_mode) begin
          if (req_i.sample != held_level_q) begin
            held_level_d  = req_i.sample;
            age_timer_d   = '0;
            change_flag_d = 1'b1;
          end else begin
            age_timer_d = sat_add(age_timer_q, req_i.elapsed);
          end
        end else if (running_q) begin
          if (timer_sum > {{(AgeW - TimeW){1'b0}}, step_durations_q[step_index_q]}) begin
            step_timer_d = '0;
            strobe       = 1'b1;
            if (next_idx < eff_len) begin
              step_index_d = next_idx[StepW-1:0];
              drive        = step_levels_q[next_idx[StepW-1:0]];
            end else begin
              step_index_d = '0;
              if (cfg_i.repeat_enable) begin
                drive = step_levels_q[0];
              end else begin
                running_d = 1'b0;
                drive     = cfg_i.idle_level;
              end
            end
          end else begin
            step_timer_d = timer_sum;
          end
        end
      end
      OpStart: begin
        if (!running_q) begin
          step_index_d = '0;
          step_timer_d = '0;
          running_d    = 1'b1;
          drive        = step_levels_q[0];
          strobe       = 1'b1;
        end
      end
      OpAck: begin
        change_flag_d = 1'b0;
      end
      default: begin
        // table loads only touch the step arrays
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_level_q  <= '0;
      age_timer_q   <= '0;
      change_flag_q <= 1'b0;
      running_q     <= 1'b0;
      step_index_q  <= '0;
      step_timer_q  <= '0;
    end else if (en_i) begin
      held_level_q  <= held_level_d;
      age_timer_q   <= age_timer_d;
      change_flag_q <= change_flag_d;
      running_q     <= running_d;
      step_index_q  <= step_index_d;
      step_timer_q  <= step_timer_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && req_i.op == OpLoad) begin
      step_levels_q[req_i.entry_index]    <= req_i.entry_level;
      step_durations_q[req_i.entry_index] <= req_i.entry_duration;
    end
  end

  always_comb begin
    rsp_o.drive_level   = drive;
    rsp_o.drive_strobe  = strobe;
    rsp_o.input_level   = held_level_d;
    rsp_o.level_age     = age_timer_d;
    rsp_o.level_changed = change_flag_d;
    rsp_o.seq_running   = running_d;
    rsp_o.seq_step      = step_index_d;
  end

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for one pin channel: level monitor and step sequence player
`timescale 1ns / 1ps

module testbench;
  import plts_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldTicks  = 20;
  localparam int unsigned NumPhases  = 16;
  localparam int unsigned PhaseReqs  = 80;

  class pin_channel_scoreboard;
    // register mirror
    logic              out_mode;
    logic [LevelW-1:0] idle_lvl;
    logic [LenW-1:0]   seq_len;
    logic              wrap;
    // channel state
    logic [LevelW-1:0] held;
    logic [AgeW-1:0]   age;
    logic              changed;
    logic              running;
    logic [StepW-1:0]  step;
    logic [AgeW-1:0]   step_time;
    logic [LevelW-1:0] step_lvl [SeqDepth];
    logic [TimeW-1:0]  step_dur [SeqDepth];
    rsp_t              expected_rsp [$];
    int unsigned       errors;

    function new();
      out_mode  = 1'b0;
      idle_lvl  = '0;
      seq_len   = LenW'(1);
      wrap      = 1'b0;
      held      = '0;
      age       = '0;
      changed   = 1'b0;
      running   = 1'b0;
      step      = '0;
      step_time = '0;
      errors    = 0;
    endfunction

    function void write_reg(reg_e which, logic [DataW-1:0] v);
      case (which)
        RegOutputMode:   out_mode = v[0];
        RegIdleLevel:    idle_lvl = v[LevelW-1:0];
        RegSeqLength:    seq_len  = v[LenW-1:0];
        RegRepeatEnable: wrap     = v[0];
        default: ;
      endcase
    endfunction

    function logic [AgeW-1:0] add_clamped(logic [AgeW-1:0] a, logic [TimeW-1:0] b);
      logic [AgeW:0] sum;
      sum = {1'b0, a} + (AgeW + 1)'(b);
      return sum[AgeW] ? {AgeW{1'b1}} : sum[AgeW-1:0];
    endfunction

    function void note_request(req_t r);
      rsp_t        e;
      int unsigned steps;
      e = '0;
      // zero length plays one step, oversize plays the whole table
      steps = (seq_len == '0) ? 1 :
              ((seq_len > LenW'(SeqDepth)) ? SeqDepth : int'(seq_len));
      case (r.op)
        OpTick: begin
          if (!out_mode) begin
            if (r.sample != held) begin
              held    = r.sample;
              age     = '0;
              changed = 1'b1;
            end else begin
              age = add_clamped(age, r.elapsed);
            end
          end else if (running) begin
            step_time = add_clamped(step_time, r.elapsed);
            if (step_time > AgeW'(step_dur[step])) begin
              step_time      = '0;
              e.drive_strobe = 1'b1;
              if (int'(step) + 1 < steps) begin
                step          = step + 1'b1;
                e.drive_level = step_lvl[step];
              end else begin
                step = '0;
                if (wrap) begin
                  e.drive_level = step_lvl[0];
                end else begin
                  running       = 1'b0;
                  e.drive_level = idle_lvl;
                end
              end
            end
          end
        end
        OpLoad: begin
          step_lvl[r.entry_index] = r.entry_level;
          step_dur[r.entry_index] = r.entry_duration;
        end
        OpStart: begin
          if (!running) begin
            step           = '0;
            step_time      = '0;
            running        = 1'b1;
            e.drive_level  = step_lvl[0];
            e.drive_strobe = 1'b1;
          end
        end
        default: changed = 1'b0;
      endcase
      e.input_level   = held;
      e.level_age     = age;
      e.level_changed = changed;
      e.seq_running   = running;
      e.seq_step      = step;
      expected_rsp.push_back(e);
    endfunction

    function void compare_field(string field, logic [AgeW-1:0] exp_v, logic [AgeW-1:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(rsp_t got);
      rsp_t e;
      if (expected_rsp.size() == 0) begin
        $error("result with no request outstanding: %p", got);
        errors++;
        return;
      end
      e = expected_rsp.pop_front();
      compare_field("drive_level", AgeW'(e.drive_level), AgeW'(got.drive_level));
      compare_field("drive_strobe", AgeW'(e.drive_strobe), AgeW'(got.drive_strobe));
      compare_field("input_level", AgeW'(e.input_level), AgeW'(got.input_level));
      compare_field("level_age", e.level_age, got.level_age);
      compare_field("level_changed", AgeW'(e.level_changed), AgeW'(got.level_changed));
      compare_field("seq_running", AgeW'(e.seq_running), AgeW'(got.seq_running));
      compare_field("seq_step", AgeW'(e.seq_step), AgeW'(got.seq_step));
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [AddrW-1:0]  paddr     = '0;
  logic [DataW-1:0]  pwdata    = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  req_t              in_req    = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  rsp_t              out_rsp;

  pin_channel_scoreboard sb = new();

  int unsigned       gap_pct      = 0;
  int unsigned       stall_pct    = 0;
  int unsigned       quiet_cycles = 0;
  logic [LevelW-1:0] last_sample  = '0;

  pin_level_timer_and_sequence_player u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (in_valid && !in_stall) sb.note_request(in_req);
    if (out_valid && !out_stall) sb.check_result(out_rsp);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("pin_level_timer_and_sequence_player verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input req_t r);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_req   <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // let every outstanding request come back, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_rsp.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input reg_e which, input logic [DataW-1:0] v);
    logic [DataW-1:0] rd;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {which, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(which, v);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== v) begin
      $error("%s readback: expected %0d, got %0d", which.name(), v, rd);
      sb.errors++;
    end
  endtask

  task automatic configure(input logic mode, input logic [LevelW-1:0] idle,
                           input logic [LenW-1:0] len, input logic rpt);
    drain();
    set_reg(RegOutputMode, DataW'(mode));
    set_reg(RegIdleLevel, DataW'(idle));
    set_reg(RegSeqLength, DataW'(len));
    set_reg(RegRepeatEnable, DataW'(rpt));
  endtask

  function automatic req_t make_req(input op_e op, input logic [TimeW-1:0] elapsed,
                                    input logic [LevelW-1:0] sample,
                                    input logic [StepW-1:0] idx,
                                    input logic [LevelW-1:0] lvl,
                                    input logic [TimeW-1:0] dur);
    req_t r;
    r.op             = op;
    r.elapsed        = elapsed;
    r.sample         = sample;
    r.entry_index    = idx;
    r.entry_level    = lvl;
    r.entry_duration = dur;
    return r;
  endfunction

  function automatic req_t random_req(input logic out_mode);
    req_t        r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65)      r.op = OpTick;
    else if (pick < 77) r.op = OpLoad;
    else if (pick < 89) r.op = OpStart;
    else                r.op = OpAck;
    r.elapsed = ($urandom_range(0, 9) < 7) ? TimeW'($urandom_range(0, 40))
                                           : TimeW'($urandom_range(0, 65535));
    // in monitor mode mostly repeat the level so the age keeps growing
    if (!out_mode && $urandom_range(0, 3) != 0) r.sample = last_sample;
    else r.sample = LevelW'($urandom_range(0, 1023));
    if (r.op == OpTick) last_sample = r.sample;
    r.entry_index    = StepW'($urandom_range(0, SeqDepth - 1));
    r.entry_level    = LevelW'($urandom_range(0, 1023));
    r.entry_duration = ($urandom_range(0, 4) != 0) ? TimeW'($urandom_range(0, 60))
                                                   : TimeW'($urandom_range(0, 65535));
    return r;
  endfunction

  initial begin
    logic              mode;
    logic [LevelW-1:0] idle;
    logic [LenW-1:0]   len;
    logic [LevelW-1:0] lvl;
    logic [TimeW-1:0]  dur;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: monitor mode, ack, change, age, table fill, start in monitor mode
    configure(1'b0, 10'h3FF, 5'd2, 1'b0);
    send(make_req(OpAck, '0, '0, '0, '0, '0));
    send(make_req(OpTick, 16'hFFFF, '0, '0, '0, '0));
    send(make_req(OpTick, '0, 10'h3FF, '0, '0, '0));
    send(make_req(OpTick, 16'h0001, 10'h3FF, '0, '0, '0));
    send(make_req(OpAck, '0, '0, '0, '0, '0));
    // every table entry is loaded before anything can play it
    for (int i = 0; i < SeqDepth; i++) begin
      lvl = (i == 0) ? 10'h3FF : ((i == SeqDepth - 1) ? 10'h000 : LevelW'($urandom_range(0, 1023)));
      dur = (i == 0) ? 16'h0000 : ((i == SeqDepth - 1) ? 16'hFFFF : TimeW'($urandom_range(0, 30)));
      send(make_req(OpLoad, '0, '0, StepW'(i), lvl, dur));
    end
    send(make_req(OpStart, '0, '0, '0, '0, '0));
    send(make_req(OpStart, '0, '0, '0, '0, '0));
    send(make_req(OpTick, 16'hFFFF, 10'h3FF, '0, '0, '0));

    // hold one level with large steps so the age grows fast
    configure(1'b0, 10'h000, 5'd1, 1'b0);
    for (int i = 0; i < HoldTicks; i++) begin
      send(make_req(OpTick, 16'hFFFF, 10'h155, '0, '0, '0));
    end
    last_sample = 10'h155;

    for (int ph = 0; ph < NumPhases; ph++) begin
      mode = (ph % 3 != 0);
      case (ph % 4)
        0: idle = 10'h3FF;
        1: idle = 10'h000;
        default: idle = LevelW'($urandom_range(0, 1023));
      endcase
      case (ph % 8)
        0: len = 5'd1;
        1: len = 5'd16;
        2: len = 5'd0;
        3: len = 5'd31;
        4: len = 5'd17;
        default: len = LenW'($urandom_range(1, 16));
      endcase
      configure(mode, idle, len, ((ph / 2) % 2) == 1);
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 59; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 59; end
        default: begin gap_pct = 24; stall_pct = 24; end
      endcase
      for (int n = 0; n < PhaseReqs; n++) begin
        send(random_req(mode));
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("pin_level_timer_and_sequence_player verification clean");
    end else begin
      $display("pin_level_timer_and_sequence_player verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/plts_pkg.sv
hdl/plts_core.sv
hdl/pin_level_timer_and_sequence_player.sv
bench/testbench.sv
